// File: sv/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque: ring size, operation and
// status codes, the request and response payloads, and the internal structs
// that pass between the control logic and the datapath.
// ----------------------------------------------------------------------------
package cdq_pkg;

  // Ring store geometry.
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DATA_W = 32;

  // Operation carried by each request.
  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_REAR  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } mode_t;

  // Outcome reported with each response.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef logic [IDX_W-1:0] idx_t;

  // Input request payload.
  typedef struct packed {
    mode_t                     mode;
    logic signed [DATA_W-1:0]  push_value;
  } in_req_t;

  // Output response payload.
  typedef struct packed {
    logic signed [DATA_W-1:0]  pop_value;
    status_t                   status;
    logic                      is_empty;
    logic                      is_full;
  } out_rsp_t;

  // Access to the ring store issued by the control logic.
  typedef struct packed {
    logic               we;
    logic               re;
    idx_t               addr;
    logic [DATA_W-1:0]  wdata;
  } ram_req_t;

  // Per-request outcome that travels alongside the store read.
  typedef struct packed {
    status_t  status;
    logic     pop_ok;
    logic     is_empty;
    logic     is_full;
  } step_info_t;

  // Ring index arithmetic with wrap at DEPTH.
  function automatic idx_t wrap_inc(idx_t i);
    idx_t r;
    if (i == idx_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + idx_t'(1);
    end
    return r;
  endfunction

  function automatic idx_t wrap_dec(idx_t i);
    idx_t r;
    if (i == '0) begin
      r = idx_t'(DEPTH - 1);
    end else begin
      r = i - idx_t'(1);
    end
    return r;
  endfunction

endpackage

// File: sv/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// Single-port synchronous RAM with registered read data.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int unsigned DEPTH_P = 16,
  parameter int unsigned WIDTH_P = 32,
  parameter int unsigned ADDR_W  = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic               re,
  input  logic [ADDR_W-1:0]  addr,
  input  logic [WIDTH_P-1:0] wdata,
  output logic [WIDTH_P-1:0] rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];
  logic [WIDTH_P-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Head, tail and empty bookkeeping of the deque. For each accepted request it
// decides the outcome, issues at most one store access and updates the
// pointers in the same cycle.
// ----------------------------------------------------------------------------
module cdq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  cdq_pkg::in_req_t     req,
  output cdq_pkg::ram_req_t    ram_req,
  output cdq_pkg::step_info_t  info,
  output logic                 cur_empty
);

  cdq_pkg::idx_t head_r, head_nxt;
  cdq_pkg::idx_t tail_r, tail_nxt;
  logic          empty_r, empty_nxt;
  logic          full_now;
  logic          is_push;

  assign full_now  = !empty_r && (cdq_pkg::wrap_inc(tail_r) == head_r);
  assign is_push   = (req.mode == cdq_pkg::MODE_PUSH_FRONT) ||
                     (req.mode == cdq_pkg::MODE_PUSH_REAR);
  assign cur_empty = empty_r;

  // Outcome, store access and next pointers for the current request.
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    empty_nxt     = empty_r;
    ram_req.we    = 1'b0;
    ram_req.re    = 1'b0;
    ram_req.addr  = head_r;
    ram_req.wdata = req.push_value;
    info.status   = cdq_pkg::ST_DONE;
    info.pop_ok   = 1'b0;

    if (is_push) begin
      if (full_now) begin
        info.status = cdq_pkg::ST_OVERFLOW;
      end else if (empty_r) begin
        // First entry always lands in slot zero.
        head_nxt     = '0;
        tail_nxt     = '0;
        empty_nxt    = 1'b0;
        ram_req.we   = take;
        ram_req.addr = '0;
      end else if (req.mode == cdq_pkg::MODE_PUSH_FRONT) begin
        head_nxt     = cdq_pkg::wrap_dec(head_r);
        ram_req.we   = take;
        ram_req.addr = head_nxt;
      end else begin
        tail_nxt     = cdq_pkg::wrap_inc(tail_r);
        ram_req.we   = take;
        ram_req.addr = tail_nxt;
      end
    end else begin
      if (empty_r) begin
        info.status = cdq_pkg::ST_UNDERFLOW;
      end else begin
        info.pop_ok  = 1'b1;
        ram_req.re   = take;
        ram_req.addr = (req.mode == cdq_pkg::MODE_POP_FRONT) ? head_r : tail_r;
        if (head_r == tail_r) begin
          // Last entry removed: pointers return to the origin.
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b1;
        end else if (req.mode == cdq_pkg::MODE_POP_FRONT) begin
          head_nxt = cdq_pkg::wrap_inc(head_r);
        end else begin
          tail_nxt = cdq_pkg::wrap_dec(tail_r);
        end
      end
    end

    info.is_empty = empty_nxt;
    info.is_full  = !empty_nxt && (cdq_pkg::wrap_inc(tail_nxt) == head_nxt);
  end

  // Pointer and flag registers advance only on an accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else if (take) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

endmodule

// File: sv/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed 32-bit words held in a ring store RAM.
// Push and pop at either end; every request yields one response with status
// and the empty and full flags after the step.
//
//   Channel   Ports                        Direction  Payload
//   request   in_valid  in_stall  in_req    in         mode, push_value
//   response  out_valid out_stall out_rsp   out        pop_value, status,
//                                                      is_empty, is_full
//
// One request per cycle is sustained while the output is not stalled; each
// response passes through the store read stage, then the output register.
// The single store port is used at most once per request, so a push followed by a pop
// of the same slot reads the written value with no forwarding needed.
// Reset clears the pointers and marks the deque empty; no clearing pass.
// A stalled output holds the store stage, which in turn stalls the input.
// ----------------------------------------------------------------------------
module circular_deque (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cdq_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output cdq_pkg::out_rsp_t out_rsp
);

  cdq_pkg::ram_req_t   ram_req;
  cdq_pkg::step_info_t step_info;
  cdq_pkg::step_info_t s1_info_r;
  logic                s1_valid_r;
  logic                s1_adv;
  logic                take;
  logic                cur_empty;
  logic [cdq_pkg::DATA_W-1:0] rdata;
  cdq_pkg::out_rsp_t   out_rsp_r, out_rsp_nxt;
  logic                out_valid_r;

  // Handshake: the store stage moves on when the output register is empty or not stalled.
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign take     = in_valid && !in_stall;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .req       (in_req),
    .ram_req   (ram_req),
    .info      (step_info),
    .cur_empty (cur_empty)
  );

  cdq_ram #(
    .DEPTH_P (cdq_pkg::DEPTH),
    .WIDTH_P (cdq_pkg::DATA_W),
    .ADDR_W  (cdq_pkg::IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .re    (ram_req.re),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (rdata)
  );

  // Store stage: outcome waits here while the read completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_info_r <= step_info;
    end
  end

  // Response assembly: pop data only for a successful pop.
  always_comb begin
    out_rsp_nxt.pop_value = s1_info_r.pop_ok ? rdata : '0;
    out_rsp_nxt.status    = s1_info_r.status;
    out_rsp_nxt.is_empty  = s1_info_r.is_empty;
    out_rsp_nxt.is_full   = s1_info_r.is_full;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // A pop accepted on an empty deque must report underflow.
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (take && cur_empty &&
     (in_req.mode == cdq_pkg::MODE_POP_FRONT || in_req.mode == cdq_pkg::MODE_POP_REAR))
    |=> (s1_info_r.status == cdq_pkg::ST_UNDERFLOW))
    else $error("pop on empty deque did not report underflow");

  // Refused operations return no data.
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rsp_r.status != cdq_pkg::ST_DONE) |-> (out_rsp_r.pop_value == '0))
    else $error("refused request returned nonzero data");

  // Empty and full cannot both be reported.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_rsp_r.is_empty && out_rsp_r.is_full))
    else $error("response reports empty and full together");

  // A blocked store stage keeps its outcome.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_info_r)))
    else $error("store stage changed while blocked");

endmodule
